// ----- rtl/core/wcag_pkg.sv -----
// ----------------------------------------------------------------------------
// Watermark credit admission gate package
// Shared payload types, configuration layout, register map and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wcag_pkg;

   // Limit on concurrently held reservations.
   localparam int unsigned MAX_BATCHES = 128;
   localparam int unsigned BATCH_W     = 8;
   localparam int unsigned REC_HELD_W  = 15;
   localparam int unsigned BYTE_HELD_W = 23;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 3;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_HIGH_RECORDS      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_BYTES        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_AGE_SECONDS  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LOW_RECORDS       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LOW_BYTES         = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LOW_AGE_SECONDS   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_RECORDS_PER_BATCH = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_BATCH   = 3'd7;

   // Action codes.
   localparam logic [1:0] ACTION_UPDATE  = 2'd0;
   localparam logic [1:0] ACTION_RESERVE = 2'd1;
   localparam logic [1:0] ACTION_RELEASE = 2'd2;

   // Status codes.
   localparam logic [2:0] STATUS_DONE        = 3'd0;
   localparam logic [2:0] STATUS_RESERVED    = 3'd1;
   localparam logic [2:0] STATUS_UNHEALTHY   = 3'd2;
   localparam logic [2:0] STATUS_HIGH_MARK   = 3'd3;
   localparam logic [2:0] STATUS_EXHAUSTED   = 3'd4;
   localparam logic [2:0] STATUS_NO_RESERVED = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [23:0] backlog_records;
      logic [31:0] backlog_bytes;
      logic [19:0] oldest_age_seconds;
      logic        storage_healthy;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic                   blocked;
      logic [BATCH_W-1:0]     batches_held;
      logic [REC_HELD_W-1:0]  records_held;
      logic [BYTE_HELD_W-1:0] bytes_held;
   } rsp_type;

   typedef struct packed {
      logic [23:0] high_records;
      logic [31:0] high_bytes;
      logic [19:0] high_age_seconds;
      logic [23:0] low_records;
      logic [31:0] low_bytes;
      logic [19:0] low_age_seconds;
      logic [7:0]  records_per_batch;
      logic [15:0] bytes_per_batch;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      high_records:      24'd5000,
      high_bytes:        32'h0400_0000,
      high_age_seconds:  20'd900,
      low_records:       24'd4000,
      low_bytes:         32'h0300_0000,
      low_age_seconds:   20'd600,
      records_per_batch: 8'd11,
      bytes_per_batch:   16'd2378
   };

endpackage

`default_nettype wire

// ----- rtl/core/wcag_csr.sv -----
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style register bank holding the watermarks and per-batch sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module wcag_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [wcag_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [wcag_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [wcag_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output wcag_pkg::cfg_type                     cfg
);

   wcag_pkg::cfg_type                 cfg_ff;
   wcag_pkg::cfg_type                 cfg_in;
   logic [wcag_pkg::REG_IDX_W-1:0]    reg_idx;
   logic                              wr_en;

   assign reg_idx    = csr_paddr[wcag_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            wcag_pkg::REG_HIGH_RECORDS:      cfg_in.high_records = csr_pwdata[23:0];
            wcag_pkg::REG_HIGH_BYTES:        cfg_in.high_bytes = csr_pwdata;
            wcag_pkg::REG_HIGH_AGE_SECONDS:  cfg_in.high_age_seconds = csr_pwdata[19:0];
            wcag_pkg::REG_LOW_RECORDS:       cfg_in.low_records = csr_pwdata[23:0];
            wcag_pkg::REG_LOW_BYTES:         cfg_in.low_bytes = csr_pwdata;
            wcag_pkg::REG_LOW_AGE_SECONDS:   cfg_in.low_age_seconds = csr_pwdata[19:0];
            wcag_pkg::REG_RECORDS_PER_BATCH: cfg_in.records_per_batch = csr_pwdata[7:0];
            wcag_pkg::REG_BYTES_PER_BATCH:   cfg_in.bytes_per_batch = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         wcag_pkg::REG_HIGH_RECORDS:      csr_prdata = {8'd0, cfg_ff.high_records};
         wcag_pkg::REG_HIGH_BYTES:        csr_prdata = cfg_ff.high_bytes;
         wcag_pkg::REG_HIGH_AGE_SECONDS:  csr_prdata = {12'd0, cfg_ff.high_age_seconds};
         wcag_pkg::REG_LOW_RECORDS:       csr_prdata = {8'd0, cfg_ff.low_records};
         wcag_pkg::REG_LOW_BYTES:         csr_prdata = cfg_ff.low_bytes;
         wcag_pkg::REG_LOW_AGE_SECONDS:   csr_prdata = {12'd0, cfg_ff.low_age_seconds};
         wcag_pkg::REG_RECORDS_PER_BATCH: csr_prdata = {24'd0, cfg_ff.records_per_batch};
         wcag_pkg::REG_BYTES_PER_BATCH:   csr_prdata = {16'd0, cfg_ff.bytes_per_batch};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wcag_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/wcag_step.sv -----
// ----------------------------------------------------------------------------
// Admission step
// Holds the backlog snapshot, blocking flag and reservation counters, and
// evaluates one transaction against them.
// ----------------------------------------------------------------------------
`default_nettype none

module wcag_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wcag_pkg::cfg_type cfg,
   input  wire logic              item_valid,
   input  wire wcag_pkg::req_type item,
   output wcag_pkg::rsp_type      result
);

   logic [23:0]                          snap_records_ff, snap_records_in;
   logic [31:0]                          snap_bytes_ff, snap_bytes_in;
   logic [19:0]                          snap_age_ff, snap_age_in;
   logic                                 snap_healthy_ff, snap_healthy_in;
   logic                                 block_flag_ff, block_flag_in;
   logic                                 seen_update_ff, seen_update_in;
   logic [wcag_pkg::BATCH_W-1:0]         held_batches_ff, held_batches_in;
   logic [wcag_pkg::REC_HELD_W-1:0]      held_records_ff, held_records_in;
   logic [wcag_pkg::BYTE_HELD_W-1:0]     held_bytes_ff, held_bytes_in;

   logic                                 over_high;
   logic                                 under_low;
   logic [25:0]                          rec_total;
   logic [33:0]                          byte_total;
   logic                                 exhausted;
   logic [wcag_pkg::REC_HELD_W:0]        rec_sum;
   logic [wcag_pkg::BYTE_HELD_W:0]       byte_sum;
   logic [wcag_pkg::REC_HELD_W-1:0]      rec_per;
   logic [wcag_pkg::BYTE_HELD_W-1:0]     byte_per;
   logic [2:0]                           status;

   assign rec_per  = wcag_pkg::REC_HELD_W'(cfg.records_per_batch);
   assign byte_per = wcag_pkg::BYTE_HELD_W'(cfg.bytes_per_batch);

   // Age only matters when there are records pending.
   assign over_high = (item.backlog_records >= cfg.high_records) ||
                      (item.backlog_bytes >= cfg.high_bytes) ||
                      ((item.backlog_records != 24'd0) &&
                       (item.oldest_age_seconds >= cfg.high_age_seconds));
   assign under_low = (item.backlog_records <= cfg.low_records) &&
                      (item.backlog_bytes <= cfg.low_bytes) &&
                      ((item.backlog_records == 24'd0) ||
                       (item.oldest_age_seconds < cfg.low_age_seconds));

   assign rec_total  = 26'(snap_records_ff) + 26'(held_records_ff) +
                       26'(cfg.records_per_batch);
   assign byte_total = 34'(snap_bytes_ff) + 34'(held_bytes_ff) +
                       34'(cfg.bytes_per_batch);
   assign exhausted  = (held_batches_ff >= wcag_pkg::BATCH_W'(wcag_pkg::MAX_BATCHES)) ||
                       (rec_total > 26'(cfg.high_records)) ||
                       (byte_total > 34'(cfg.high_bytes));

   assign rec_sum  = {1'b0, held_records_ff} + {1'b0, rec_per};
   assign byte_sum = {1'b0, held_bytes_ff} + {1'b0, byte_per};

   always_comb begin
      snap_records_in = snap_records_ff;
      snap_bytes_in   = snap_bytes_ff;
      snap_age_in     = snap_age_ff;
      snap_healthy_in = snap_healthy_ff;
      block_flag_in   = block_flag_ff;
      seen_update_in  = seen_update_ff;
      held_batches_in = held_batches_ff;
      held_records_in = held_records_ff;
      held_bytes_in   = held_bytes_ff;
      status          = wcag_pkg::STATUS_DONE;

      priority if (item.action == wcag_pkg::ACTION_UPDATE) begin
         snap_records_in = item.backlog_records;
         snap_bytes_in   = item.backlog_bytes;
         snap_age_in     = item.oldest_age_seconds;
         snap_healthy_in = item.storage_healthy;
         // The first update sets blocking directly; later ones use hysteresis.
         if (!seen_update_ff) begin
            seen_update_in = 1'b1;
            block_flag_in  = !item.storage_healthy || over_high;
         end else if (!item.storage_healthy) begin
            block_flag_in = 1'b1;
         end else if (block_flag_ff) begin
            block_flag_in = !under_low;
         end else if (over_high) begin
            block_flag_in = 1'b1;
         end
      end else if (item.action == wcag_pkg::ACTION_RESERVE) begin
         if (!snap_healthy_ff) begin
            status = wcag_pkg::STATUS_UNHEALTHY;
         end else if (block_flag_ff) begin
            status = wcag_pkg::STATUS_HIGH_MARK;
         end else if (exhausted) begin
            status = wcag_pkg::STATUS_EXHAUSTED;
         end else begin
            status          = wcag_pkg::STATUS_RESERVED;
            held_batches_in = held_batches_ff + 1'b1;
            held_records_in = rec_sum[wcag_pkg::REC_HELD_W] ? '1 :
                              rec_sum[wcag_pkg::REC_HELD_W-1:0];
            held_bytes_in   = byte_sum[wcag_pkg::BYTE_HELD_W] ? '1 :
                              byte_sum[wcag_pkg::BYTE_HELD_W-1:0];
         end
      end else if (item.action == wcag_pkg::ACTION_RELEASE) begin
         if (held_batches_ff == '0) begin
            status = wcag_pkg::STATUS_NO_RESERVED;
         end else begin
            // The per-batch size may have changed since the grant, so floor at zero.
            held_batches_in = held_batches_ff - 1'b1;
            held_records_in = (held_records_ff > rec_per) ?
                              held_records_ff - rec_per : '0;
            held_bytes_in   = (held_bytes_ff > byte_per) ?
                              held_bytes_ff - byte_per : '0;
         end
      end else begin
         status = wcag_pkg::STATUS_DONE;
      end
   end

   assign result.status       = status;
   assign result.blocked      = block_flag_in;
   assign result.batches_held = held_batches_in;
   assign result.records_held = held_records_in;
   assign result.bytes_held   = held_bytes_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_records_ff <= '0;
         snap_bytes_ff   <= '0;
         snap_age_ff     <= '0;
         snap_healthy_ff <= 1'b0;
         block_flag_ff   <= 1'b1;
         seen_update_ff  <= 1'b0;
         held_batches_ff <= '0;
         held_records_ff <= '0;
         held_bytes_ff   <= '0;
      end else if (item_valid) begin
         snap_records_ff <= snap_records_in;
         snap_bytes_ff   <= snap_bytes_in;
         snap_age_ff     <= snap_age_in;
         snap_healthy_ff <= snap_healthy_in;
         block_flag_ff   <= block_flag_in;
         seen_update_ff  <= seen_update_in;
         held_batches_ff <= held_batches_in;
         held_records_ff <= held_records_in;
         held_bytes_ff   <= held_bytes_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/watermark_credit_admission_gate.sv -----
// A request transaction accepted is held in the input register, and its response
// is registered in the result register once that register is free or drains.
// Throughput: one transaction per cycle while responses are taken; all work for a
// transaction is done in the single logic stage between the two registers.
// Reset (synchronous, active high) restores register defaults, clears the
// snapshot and counters, sets the gate blocked and empties both registers.
// ----------------------------------------------------------------------------
// Watermark credit admission gate
// Admission control with watermark hysteresis and reservation accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module watermark_credit_admission_gate (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire wcag_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output wcag_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [wcag_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [wcag_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [wcag_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   wcag_pkg::cfg_type  cfg;
   wcag_pkg::rsp_type  result;

   logic               in_valid_ff, in_valid_in;
   wcag_pkg::req_type  in_data_ff, in_data_in;
   logic               out_valid_ff, out_valid_in;
   wcag_pkg::rsp_type  out_data_ff, out_data_in;
   logic               advance;

   wcag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wcag_step u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (advance),
      .item       (in_data_ff),
      .result     (result)
   );

   // The held transaction moves on whenever the result register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Admission gate testbench
// Drives update, reserve and release transactions through the watermark
// admission gate under random idling on both channels. Every response is
// compared field by field against an in-bench model of the gate's hysteresis
// and reservation accounting, across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam logic [1:0] ACTION_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;

   typedef struct packed {
      logic              known;
      wcag_pkg::rsp_type value;
   } fixed_answer_type;

   typedef struct packed {
      wcag_pkg::req_type item;
      fixed_answer_type  answer;
   } plan_row_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   wcag_pkg::req_type               req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   wcag_pkg::rsp_type               rsp_data;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [wcag_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [wcag_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [wcag_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Gate model state and its copy of the registers.
   wcag_pkg::cfg_type csr_shadow = wcag_pkg::CFG_RESET;
   logic [23:0] seen_rec   = '0;
   logic [31:0] seen_bytes = '0;
   logic [19:0] seen_age   = '0;
   logic        seen_ok    = 1'b0;
   logic        gate_shut  = 1'b1;
   logic        primed     = 1'b0;
   logic [7:0]  hold_cnt   = '0;
   logic [14:0] hold_rec   = '0;
   logic [22:0] hold_byt   = '0;

   wcag_pkg::rsp_type pending_verdicts [$];
   fixed_answer_type  answer_notes [$];
   plan_row_type      directed_plan [$];

   int error_count    = 0;
   int sent_count     = 0;
   int responses_seen = 0;
   int cycle_count    = 0;
   int settings_used  = 1;
   int long_holds     = 0;
   int grants         = 0;
   int mark_refusals  = 0;
   int exhaustions    = 0;
   int empty_releases = 0;
   bit tx_quiet        = 1'b0;
   bit rx_quiet        = 1'b0;
   bit rx_hold_pending = 1'b0;

   watermark_credit_admission_gate u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic above_high(input logic [23:0] r, input logic [31:0] b,
                                       input logic [19:0] a);
      return r >= csr_shadow.high_records || b >= csr_shadow.high_bytes ||
             (r != 24'd0 && a >= csr_shadow.high_age_seconds);
   endfunction

   // Applies one transaction to the gate model and returns its response.
   function automatic wcag_pkg::rsp_type admit_step(input wcag_pkg::req_type t);
      wcag_pkg::rsp_type o;
      logic [25:0]       rec_need;
      logic [33:0]       byte_need;
      logic [15:0]       rec_sum;
      logic [23:0]       byte_sum;
      o = '0;
      o.status = wcag_pkg::STATUS_DONE;
      case (t.action)
         wcag_pkg::ACTION_UPDATE: begin
            seen_rec   = t.backlog_records;
            seen_bytes = t.backlog_bytes;
            seen_age   = t.oldest_age_seconds;
            seen_ok    = t.storage_healthy;
            if (!primed) begin
               primed    = 1'b1;
               gate_shut = !t.storage_healthy || above_high(seen_rec, seen_bytes, seen_age);
            end else if (!t.storage_healthy) begin
               gate_shut = 1'b1;
            end else if (gate_shut) begin
               // Hysteresis: reopen only once every term is under its low mark.
               gate_shut = !(seen_rec <= csr_shadow.low_records &&
                             seen_bytes <= csr_shadow.low_bytes &&
                             (seen_rec == 24'd0 || seen_age < csr_shadow.low_age_seconds));
            end else if (above_high(seen_rec, seen_bytes, seen_age)) begin
               gate_shut = 1'b1;
            end
         end
         wcag_pkg::ACTION_RESERVE: begin
            rec_need  = 26'(seen_rec) + 26'(hold_rec) + 26'(csr_shadow.records_per_batch);
            byte_need = 34'(seen_bytes) + 34'(hold_byt) + 34'(csr_shadow.bytes_per_batch);
            if (!seen_ok) begin
               o.status = wcag_pkg::STATUS_UNHEALTHY;
            end else if (gate_shut) begin
               o.status = wcag_pkg::STATUS_HIGH_MARK;
            end else if (hold_cnt >= 8'(wcag_pkg::MAX_BATCHES) ||
                         rec_need > 26'(csr_shadow.high_records) ||
                         byte_need > 34'(csr_shadow.high_bytes)) begin
               o.status = wcag_pkg::STATUS_EXHAUSTED;
            end else begin
               rec_sum  = 16'(hold_rec) + 16'(csr_shadow.records_per_batch);
               byte_sum = 24'(hold_byt) + 24'(csr_shadow.bytes_per_batch);
               hold_cnt = hold_cnt + 8'd1;
               hold_rec = (rec_sum > 16'h7FFF) ? 15'h7FFF : rec_sum[14:0];
               hold_byt = (byte_sum > 24'h7F_FFFF) ? 23'h7F_FFFF : byte_sum[22:0];
               o.status = wcag_pkg::STATUS_RESERVED;
            end
         end
         wcag_pkg::ACTION_RELEASE: begin
            if (hold_cnt == 8'd0) begin
               o.status = wcag_pkg::STATUS_NO_RESERVED;
            end else begin
               // The current per-batch sizes are returned, floored at zero.
               hold_cnt = hold_cnt - 8'd1;
               hold_rec = (hold_rec > 15'(csr_shadow.records_per_batch)) ?
                          hold_rec - 15'(csr_shadow.records_per_batch) : '0;
               hold_byt = (hold_byt > 23'(csr_shadow.bytes_per_batch)) ?
                          hold_byt - 23'(csr_shadow.bytes_per_batch) : '0;
            end
         end
         default: ;
      endcase
      o.blocked      = gate_shut;
      o.batches_held = hold_cnt;
      o.records_held = hold_rec;
      o.bytes_held   = hold_byt;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      wcag_pkg::rsp_type guess;
      wcag_pkg::rsp_type due;
      fixed_answer_type  note;
      if (!reset) begin
         if (req_valid && req_ready) begin
            note  = answer_notes.pop_front();
            guess = admit_step(req_data);
            if (note.known) guess = note.value;
            pending_verdicts.push_back(guess);
            case (guess.status)
               wcag_pkg::STATUS_RESERVED:   grants++;
               wcag_pkg::STATUS_UNHEALTHY,
               wcag_pkg::STATUS_HIGH_MARK:  mark_refusals++;
               wcag_pkg::STATUS_EXHAUSTED:  exhaustions++;
               wcag_pkg::STATUS_NO_RESERVED: empty_releases++;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (pending_verdicts.size() == 0) begin
               $error("Response transaction arrived with none expected");
               error_count++;
            end else begin
               due = pending_verdicts.pop_front();
               check_field("status", 32'(due.status), 32'(rsp_data.status));
               check_field("blocked", 32'(due.blocked), 32'(rsp_data.blocked));
               check_field("batches_held", 32'(due.batches_held),
                           32'(rsp_data.batches_held));
               check_field("records_held", 32'(due.records_held),
                           32'(rsp_data.records_held));
               check_field("bytes_held", 32'(due.bytes_held), 32'(rsp_data.bytes_held));
            end
         end
      end
   end

   // Result side: random stall per transaction, plus one long hold on request.
   initial begin : rsp_side
      int unsigned wait_cycles;
      int unsigned served;
      served = 0;
      @(posedge clock);
      forever begin
         if (rx_hold_pending) begin
            rx_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_holds++;
         end
         if (served % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
         wait_cycles = rx_quiet ? 0 : $urandom_range(0, 15);
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         served++;
      end
   end

   task automatic program_reg(input logic [wcag_pkg::REG_IDX_W-1:0] idx,
                              input logic [wcag_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $error("csr_prdata mismatch at register %0d: expected %0h, actual %0h",
                idx, value, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_config(input wcag_pkg::cfg_type c);
      program_reg(wcag_pkg::REG_HIGH_RECORDS, 32'(c.high_records));
      program_reg(wcag_pkg::REG_HIGH_BYTES, c.high_bytes);
      program_reg(wcag_pkg::REG_HIGH_AGE_SECONDS, 32'(c.high_age_seconds));
      program_reg(wcag_pkg::REG_LOW_RECORDS, 32'(c.low_records));
      program_reg(wcag_pkg::REG_LOW_BYTES, c.low_bytes);
      program_reg(wcag_pkg::REG_LOW_AGE_SECONDS, 32'(c.low_age_seconds));
      program_reg(wcag_pkg::REG_RECORDS_PER_BATCH, 32'(c.records_per_batch));
      program_reg(wcag_pkg::REG_BYTES_PER_BATCH, 32'(c.bytes_per_batch));
      csr_shadow = c;
      settings_used++;
   endtask

   task automatic send_item(input wcag_pkg::req_type item, input fixed_answer_type answer,
                            input bit rush);
      int unsigned gap;
      gap = (rush || tx_quiet) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      answer_notes.push_back(answer);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      sent_count++;
   endtask

   // Stops offering and waits until every outstanding response is back.
   task automatic drain();
      req_valid <= 1'b0;
      wait (responses_seen == sent_count);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_row(input logic [1:0] act, input logic [23:0] r, input logic [31:0] b,
                          input logic [19:0] a, input logic ok, input logic known,
                          input logic [2:0] st, input logic blk, input logic [7:0] bat,
                          input logic [14:0] rh, input logic [22:0] bh);
      plan_row_type p;
      p.item         = '{action: act, backlog_records: r, backlog_bytes: b,
                         oldest_age_seconds: a, storage_healthy: ok};
      p.answer.known = known;
      p.answer.value = '{status: st, blocked: blk, batches_held: bat,
                         records_held: rh, bytes_held: bh};
      directed_plan.push_back(p);
   endtask

   function automatic logic [31:0] upto(input logic [31:0] lim);
      return (lim == 32'hFFFF_FFFF) ? $urandom : $urandom_range(lim, 0);
   endfunction

   function automatic logic [31:0] pick_level(input logic [31:0] lo_mark,
                                              input logic [31:0] hi_mark,
                                              input logic [31:0] top);
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'd0;
         1:       v = top;
         2:       v = lo_mark;
         3:       v = lo_mark + 32'd1;
         4:       v = hi_mark;
         5:       v = hi_mark - 32'd1;
         6:       v = $urandom;
         default: v = upto(lo_mark);
      endcase
      return v & top;
   endfunction

   function automatic logic [31:0] any_level(input logic [31:0] top);
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return top;
         default: return ($urandom & top) >> $urandom_range(0, 16);
      endcase
   endfunction

   function automatic wcag_pkg::req_type make_item();
      wcag_pkg::req_type t;
      int unsigned       roll;
      t.backlog_records    = 24'($urandom);
      t.backlog_bytes      = $urandom;
      t.oldest_age_seconds = 20'($urandom);
      t.storage_healthy    = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         t.action = wcag_pkg::ACTION_RESERVE;
      end else if (roll < 68) begin
         t.action = wcag_pkg::ACTION_RELEASE;
      end else if (roll < 95) begin
         t.action = wcag_pkg::ACTION_UPDATE;
         if ($urandom_range(0, 9) < 6) begin
            // A calm snapshot sits under every low mark, so the gate can reopen.
            t.storage_healthy = ($urandom_range(0, 19) != 0);
            t.backlog_records = 24'(upto(32'(csr_shadow.low_records)) >>
                                    $urandom_range(0, 12));
            t.backlog_bytes   = upto(csr_shadow.low_bytes) >> $urandom_range(0, 16);
            if (csr_shadow.low_age_seconds == 20'd0) t.backlog_records = '0;
            if (t.backlog_records != 24'd0)
               t.oldest_age_seconds = 20'(upto(32'(csr_shadow.low_age_seconds) - 32'd1));
         end else begin
            t.storage_healthy    = ($urandom_range(0, 4) != 0);
            t.backlog_records    = 24'(pick_level(32'(csr_shadow.low_records),
                                                  32'(csr_shadow.high_records),
                                                  32'hFF_FFFF));
            t.backlog_bytes      = pick_level(csr_shadow.low_bytes,
                                              csr_shadow.high_bytes, 32'hFFFF_FFFF);
            t.oldest_age_seconds = 20'(pick_level(32'(csr_shadow.low_age_seconds),
                                                  32'(csr_shadow.high_age_seconds),
                                                  32'hF_FFFF));
         end
      end else begin
         t.action = ACTION_SPARE;
      end
      return t;
   endfunction

   task automatic run_phase(input int count, input bit pause_mid, input bit squeeze);
      if (squeeze) rx_hold_pending = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
         if (pause_mid && n == count / 2) drain();
         send_item(make_item(), '0, squeeze && n < 150);
      end
      drain();
   endtask

   function automatic wcag_pkg::cfg_type random_config();
      wcag_pkg::cfg_type c;
      c.high_records      = 24'(any_level(32'hFF_FFFF));
      c.low_records       = 24'(upto(32'(c.high_records)));
      c.high_bytes        = any_level(32'hFFFF_FFFF);
      c.low_bytes         = upto(c.high_bytes);
      c.high_age_seconds  = 20'(any_level(32'hF_FFFF));
      c.low_age_seconds   = 20'(upto(32'(c.high_age_seconds)));
      c.records_per_batch = 8'(any_level(32'hFF));
      c.bytes_per_batch   = 16'(any_level(32'hFFFF));
      return c;
   endfunction

   initial begin : stimulus
      wcag_pkg::cfg_type tight;
      tight = '{high_records: 24'd600, high_bytes: 32'd40000, high_age_seconds: 20'd50,
                low_records: 24'd400, low_bytes: 32'd20000, low_age_seconds: 20'd30,
                records_per_batch: 8'd9, bytes_per_batch: 16'd700};

      // Rows with a typed answer follow directly from the reset state.
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 1, 1, wcag_pkg::STATUS_UNHEALTHY,
              1, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RELEASE, 0, 0, 0, 1, 1, wcag_pkg::STATUS_NO_RESERVED,
              1, 0, 0, 0);
      add_row(ACTION_SPARE, '1, '1, '1, 1, 1, wcag_pkg::STATUS_DONE, 1, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 0, 0, '1, 1, 1, wcag_pkg::STATUS_DONE, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 0, 1, wcag_pkg::STATUS_RESERVED,
              0, 1, 11, 2378);
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 0, 1, wcag_pkg::STATUS_RESERVED,
              0, 2, 22, 4756);
      add_row(wcag_pkg::ACTION_RELEASE, 0, 0, 0, 0, 1, wcag_pkg::STATUS_DONE,
              0, 1, 11, 2378);
      add_row(wcag_pkg::ACTION_UPDATE, 1, 0, 900, 1, 1, wcag_pkg::STATUS_DONE,
              1, 1, 11, 2378);
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 1, 1, wcag_pkg::STATUS_HIGH_MARK,
              1, 1, 11, 2378);
      add_row(wcag_pkg::ACTION_UPDATE, 4000, 32'h0300_0000, 599, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 4999, 32'h03FF_FFFF, 899, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 5000, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 4001, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 0, 32'h0300_0001, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 3000, 0, 600, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 0, 32'h0400_0000, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, '1, '1, '1, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_UPDATE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RESERVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wcag_pkg::ACTION_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) send_item(directed_plan[i].item, directed_plan[i].answer, 1'b0);
      drain();

      run_phase(300, 1'b1, 1'b0);
      load_config('0);
      run_phase(100, 1'b0, 1'b0);
      load_config(tight);
      run_phase(400, 1'b0, 1'b1);
      load_config('1);
      run_phase(300, 1'b0, 1'b0);
      load_config(random_config());
      run_phase(200, 1'b0, 1'b0);
      load_config(random_config());
      run_phase(200, 1'b0, 1'b0);
      load_config(wcag_pkg::CFG_RESET);
      run_phase(60, 1'b0, 1'b0);

      repeat (8) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d expected responses never arrived", pending_verdicts.size());
         error_count++;
      end
      $display("Summary: %0d transactions checked over %0d register settings, %0d long holds.",
               responses_seen, settings_used, long_holds);
      $display("Reserves: %0d granted, %0d refused, %0d exhausted; %0d empty releases.",
               grants, mark_refusals, exhaustions, empty_releases);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
